FILE: design/oahm_pkg.sv
// ----------------------------------------------------------------------------
// oahm_pkg
// Shared types and constants for the open addressing hash map.
// ----------------------------------------------------------------------------
package oahm_pkg;

    localparam int DefCapacity   = 1024;
    localparam int DefKeyWidth   = 64;
    localparam int DefValueWidth = 64;

    localparam int  CountWidth = 11;
    localparam logic [CountWidth-1:0] LoadLimitReset = 11'd871;

    localparam logic [63:0] HashMul   = 64'd3079;
    localparam logic [63:0] ProbeStep = 64'd1572869;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_SPARE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_BAD_KEY   = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

endpackage

FILE: design/open_addressing_hash_map.sv
// Steps: the home bucket's key is read (S_READ) and compared (S_CHECK), then
// one read and one compare per further bucket; a lookup hit also reads the value
// (S_VREAD, S_VOUT), and a reserved key skips the probe; all end in S_OUT.
// Throughput: one item at a time, taken only once the last result has left
// the output. A 2-entry queue decouples input. Reset: synchronous active-low;
// then a clearing pass empties the key memory while the back end takes no item.
// ----------------------------------------------------------------------------
// open_addressing_hash_map
// Hash map with integer keys, linear-step probing and tombstones.
// ----------------------------------------------------------------------------
module open_addressing_hash_map import oahm_pkg::*; #(
    parameter int CAPACITY    = DefCapacity,
    parameter int KEY_WIDTH   = DefKeyWidth,
    parameter int VALUE_WIDTH = DefValueWidth,
    parameter int IN_W        = ((2 + KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
    parameter int OUT_W       = ((3 + VALUE_WIDTH + CountWidth + 1 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [10:0]       cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,  // opcode, key, value
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata   // status, found_value, live_items, load_high
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int ENTRY_W = 2 + 1 + IDX_W + KEY_WIDTH + VALUE_WIDTH;

    logic [CountWidth-1:0]  limit_reg;
    logic                   q_valid, q_pop, busy, ready_int;
    logic [ENTRY_W-1:0]     q_data;
    logic [2:0]             st;
    logic [VALUE_WIDTH-1:0] fv;
    logic [CountWidth-1:0]  live;
    logic                   lh;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LoadLimitReset;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    oahm_front #(
        .CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH),
        .IDX_W(IDX_W), .ENTRY_W(ENTRY_W)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(ready_int),
        .in_op(s_tdata[1:0]),
        .in_key(s_tdata[2 +: KEY_WIDTH]),
        .in_value(s_tdata[2 + KEY_WIDTH +: VALUE_WIDTH]),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );
    assign s_tready = ready_int;

    oahm_back #(
        .CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH),
        .IDX_W(IDX_W), .ENTRY_W(ENTRY_W)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .load_limit(limit_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_status(st), .out_value(fv), .out_live(live), .out_load_high(lh),
        .busy(busy)
    );

    assign m_tdata = OUT_W'({lh, live, fv, st});

    ap_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid) else $error("pop from empty queue");
    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    ap_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> st != 3'd7) else $error("bad status code");
    ap_idle_q: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy && q_valid |-> q_pop) else $error("idle back end ignores queue");

endmodule

FILE: design/oahm_front.sv
// ----------------------------------------------------------------------------
// oahm_front
// Accepts items, checks for reserved keys and computes the home bucket,
// then pushes the classified item into a short queue for the back end.
// ----------------------------------------------------------------------------
module oahm_front import oahm_pkg::*; #(
    parameter int CAPACITY    = DefCapacity,
    parameter int KEY_WIDTH   = DefKeyWidth,
    parameter int VALUE_WIDTH = DefValueWidth,
    parameter int IDX_W       = $clog2(CAPACITY),
    parameter int ENTRY_W     = 2 + 1 + IDX_W + KEY_WIDTH + VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             in_op,
    input  logic [KEY_WIDTH-1:0]   in_key,
    input  logic [VALUE_WIDTH-1:0] in_value,
    output logic                   q_valid,
    input  logic                   q_pop,
    output logic [ENTRY_W-1:0]     q_data
);

    localparam int Depth = 2;

    logic [ENTRY_W-1:0] fifo_reg [Depth];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;

    logic               bad_key;
    logic [63:0]        key_ext;
    logic [IDX_W-1:0]   home;
    logic               push;

    assign key_ext   = 64'(in_key);
    assign bad_key   = (key_ext == 64'd0) || (key_ext == 64'd1);
    // only the low index bits of the product matter
    assign home      = key_ext[IDX_W-1:0] * HashMul[IDX_W-1:0];

    assign in_ready = (cnt_reg != 2'(Depth));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= {in_op, bad_key, home, in_key, in_value};
        end
    end

endmodule

FILE: design/oahm_back.sv
// ----------------------------------------------------------------------------
// oahm_back
// Walks the probe chain one bucket per read, applies the operation to the
// bucket memories and counters, and holds the result in an output register.
// ----------------------------------------------------------------------------
module oahm_back import oahm_pkg::*; #(
    parameter int CAPACITY    = DefCapacity,
    parameter int KEY_WIDTH   = DefKeyWidth,
    parameter int VALUE_WIDTH = DefValueWidth,
    parameter int IDX_W       = $clog2(CAPACITY),
    parameter int ENTRY_W     = 2 + 1 + IDX_W + KEY_WIDTH + VALUE_WIDTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [CountWidth-1:0]  load_limit,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  logic [ENTRY_W-1:0]     q_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_status,
    output logic [VALUE_WIDTH-1:0] out_value,
    output logic [CountWidth-1:0]  out_live,
    output logic                   out_load_high,
    output logic                   busy
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_CHECK, S_VREAD, S_VOUT, S_OUT
    } state_t;

    localparam logic [IDX_W-1:0] Step = ProbeStep[IDX_W-1:0];
    localparam logic [IDX_W:0]   CapN = (IDX_W+1)'(CAPACITY);

    logic [KEY_WIDTH-1:0]   keys_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] vals_mem [CAPACITY];

    state_t                 state_reg;
    logic [1:0]             op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [IDX_W-1:0]       slot_reg;
    logic [IDX_W:0]         n_reg;
    logic                   has_tomb_reg;
    logic [IDX_W-1:0]       tomb_reg;
    logic [KEY_WIDTH-1:0]   rkey_reg;
    logic [VALUE_WIDTH-1:0] rval_reg;
    logic [IDX_W-1:0]       clr_reg;
    logic [CountWidth-1:0]  live_reg;
    logic [CountWidth-1:0]  tomb_cnt_reg;

    logic                   ovalid_reg;
    logic [2:0]             ostatus_reg;
    logic [VALUE_WIDTH-1:0] ovalue_reg;
    logic [CountWidth-1:0]  olive_reg;
    logic                   oload_reg;

    logic [1:0]             e_op;
    logic                   e_bad;
    logic [IDX_W-1:0]       e_home;
    logic [KEY_WIDTH-1:0]   e_key;
    logic [VALUE_WIDTH-1:0] e_val;
    logic [CountWidth:0]    used;

    assign {e_op, e_bad, e_home, e_key, e_val} = q_data;
    assign q_pop = (state_reg == S_IDLE) && q_valid && !ovalid_reg;
    assign busy  = (state_reg != S_IDLE) || ovalid_reg;

    assign out_valid     = ovalid_reg;
    assign out_status    = ostatus_reg;
    assign out_value     = ovalue_reg;
    assign out_live      = olive_reg;
    assign out_load_high = oload_reg;

    always_comb begin
        used = {1'b0, live_reg} + {1'b0, tomb_cnt_reg};
    end

    // Load flag: live items plus tombstones at or above the limit.
    function automatic logic load_of(input logic [CountWidth:0] u,
                                     input logic [CountWidth-1:0] lim);
        return u >= {1'b0, lim};
    endfunction

    always_ff @(posedge aclk) begin
        if (state_reg == S_READ) begin
            rkey_reg <= keys_mem[slot_reg];
        end
        if (state_reg == S_VREAD) begin
            rval_reg <= vals_mem[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            live_reg     <= '0;
            tomb_cnt_reg <= '0;
            ovalid_reg   <= 1'b0;
        end else begin
            if (ovalid_reg && out_ready) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    keys_mem[clr_reg] <= '0;
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IDX_W'(CAPACITY - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (q_pop) begin
                        op_reg       <= e_op;
                        key_reg      <= e_key;
                        val_reg      <= e_val;
                        slot_reg     <= e_home;
                        n_reg        <= '0;
                        has_tomb_reg <= 1'b0;
                        if (e_bad) begin
                            ostatus_reg <= ST_BAD_KEY;
                            ovalue_reg  <= '0;
                            state_reg   <= S_OUT;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    ovalue_reg <= '0;
                    state_reg  <= S_OUT;
                    if (rkey_reg == '0 || n_reg == CapN) begin
                        // chain ends: empty bucket or every bucket visited
                        if (op_reg == OP_INSERT) begin
                            if (has_tomb_reg || rkey_reg == '0) begin
                                keys_mem[has_tomb_reg ? tomb_reg : slot_reg] <= key_reg;
                                vals_mem[has_tomb_reg ? tomb_reg : slot_reg] <= val_reg;
                                live_reg <= live_reg + 1'b1;
                                if (has_tomb_reg) begin
                                    tomb_cnt_reg <= tomb_cnt_reg - 1'b1;
                                end
                                ostatus_reg <= ST_INSERTED;
                            end else begin
                                ostatus_reg <= ST_FULL;
                            end
                        end else begin
                            ostatus_reg <= ST_NOT_FOUND;
                        end
                    end else if (rkey_reg == key_reg) begin
                        case (op_reg)
                            OP_INSERT: begin
                                vals_mem[slot_reg] <= val_reg;
                                ostatus_reg <= ST_UPDATED;
                            end
                            OP_DELETE: begin
                                keys_mem[slot_reg] <= KEY_WIDTH'(1);
                                live_reg     <= live_reg - 1'b1;
                                tomb_cnt_reg <= tomb_cnt_reg + 1'b1;
                                ostatus_reg  <= ST_REMOVED;
                            end
                            default: begin
                                ostatus_reg <= ST_FOUND;
                                state_reg   <= S_VREAD;
                            end
                        endcase
                    end else begin
                        if (rkey_reg == KEY_WIDTH'(1) && !has_tomb_reg) begin
                            has_tomb_reg <= 1'b1;
                            tomb_reg     <= slot_reg;
                        end
                        slot_reg  <= slot_reg + Step;
                        n_reg     <= n_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_VREAD: begin
                    state_reg <= S_VOUT;
                end
                S_VOUT: begin
                    ovalue_reg <= rval_reg;
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    ovalid_reg <= 1'b1;
                    olive_reg  <= live_reg;
                    oload_reg  <= load_of(used, load_limit);
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
